[hdl/nedm_pkg.sv]
// package for the nearest edit-distance matcher
// types, codes, constants and helper functions shared by nedm_cell and the top level
// no dependencies
package nedm_pkg;

    localparam int QUERY_MAX_DEF     = 64;
    localparam int CANDIDATE_MAX_DEF = 512;

    localparam logic [7:0] THRESHOLD_RESET = 8'd3;
    localparam logic [7:0] DIST_SAT        = 8'd255;

    // operation codes of an input item
    localparam logic [1:0] OP_QUERY     = 2'd0;
    localparam logic [1:0] OP_CANDIDATE = 2'd1;
    localparam logic [1:0] OP_FINISH    = 2'd2;

    // result kinds
    localparam logic KIND_DISTANCE = 1'b0;
    localparam logic KIND_ANSWER   = 1'b1;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SWEEP,
        ST_EMIT
    } nedm_state_t;

    // dp wavefront handed from cell to cell
    typedef struct packed
    {
        logic       valid;
        logic [7:0] diag;
        logic [7:0] left;
    } nedm_wave_t;

    // signals broadcast to every cell
    typedef struct packed
    {
        logic       init;
        logic [7:0] symbol;
        logic       wr_en;
        logic [7:0] wr_byte;
    } nedm_bcast_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == DIST_SAT) ? v : v + 8'd1;
    endfunction

endpackage

[hdl/nearest_edit_distance_match.sv]
// top level of the nearest edit-distance matcher
// search control, result register and the chain of nedm_cell instances
// depends on nedm_pkg and nedm_cell
//
// usage:
//   input items (operation, symbol, last) are taken when in_valid is high and in_stall low.
//   a query byte does not stall the input. a candidate byte sweeps a wavefront through
//   the chain of QUERY_MAX cells, one cell per cycle, and the input stalls until it
//   leaves the last cell; the chain length alone, not the query length, sets that time.
//   after the sweep of the last byte of a candidate, the block enters the emit state and
//   loads the distance item into the output register. a finish item also moves the block
//   to the emit state, which stalls the input until its answer is in the output register.
//   result items (kind, candidate_index, distance, within_threshold, found) leave when
//   out_valid is high and out_stall low. a stalled result holds in the output register;
//   the block keeps taking items and finishing sweeps, and waits only when the next
//   result is ready while the register is still full.
//   the threshold register is written through cfg_valid/cfg_data; cfg_ready is always high.
//   reset clears the search, the query length and sets the threshold to 3; the query
//   bytes and dp row hold no defined value until written.
module nearest_edit_distance_match
#(
    parameter int QUERY_MAX     = nedm_pkg::QUERY_MAX_DEF,
    parameter int CANDIDATE_MAX = nedm_pkg::CANDIDATE_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [7:0] symbol,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [8:0] candidate_index,
    output logic [7:0] distance,
    output logic       within_threshold,
    output logic       found,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import nedm_pkg::*;

    localparam int IDX_W  = $clog2(QUERY_MAX);
    localparam int QLEN_W = $clog2(QUERY_MAX+1);
    localparam int CNT_W  = $clog2(CANDIDATE_MAX+1);
    localparam logic [QLEN_W-1:0] QLEN_MAX = QLEN_W'(QUERY_MAX);
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(CANDIDATE_MAX);

    nedm_state_t state_reg;
    nedm_state_t state_next;

    logic [QLEN_W-1:0] qlen_reg;
    logic [QLEN_W-1:0] qlen_next;
    logic              qdone_reg;
    logic              qdone_next;
    logic [7:0]        pos_reg;
    logic [7:0]        pos_next;
    logic              open_reg;
    logic              open_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  best_idx_reg;
    logic [CNT_W-1:0]  best_idx_next;
    logic [7:0]        best_cost_reg;
    logic [7:0]        best_cost_next;
    logic              have_best_reg;
    logic              have_best_next;
    logic [7:0]        thr_reg;
    logic [7:0]        thr_next;

    logic              sym_reg_valid_unused;
    logic [7:0]        sym_reg;
    logic [7:0]        sym_next;
    logic              init_reg;
    logic              init_next;
    logic              last_reg;
    logic              last_next;
    logic              launch_valid_reg;
    logic              launch_valid_next;
    logic [7:0]        launch_diag_reg;
    logic [7:0]        launch_diag_next;
    logic [7:0]        launch_left_reg;
    logic [7:0]        launch_left_next;

    logic              pend_kind_reg;
    logic              pend_kind_next;
    logic [8:0]        pend_idx_reg;
    logic [8:0]        pend_idx_next;
    logic [7:0]        pend_dist_reg;
    logic [7:0]        pend_dist_next;
    logic              pend_within_reg;
    logic              pend_within_next;
    logic              pend_found_reg;
    logic              pend_found_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_kind_reg;
    logic              out_kind_next;
    logic [8:0]        out_idx_reg;
    logic [8:0]        out_idx_next;
    logic [7:0]        out_dist_reg;
    logic [7:0]        out_dist_next;
    logic              out_within_reg;
    logic              out_within_next;
    logic              out_found_reg;
    logic              out_found_next;

    logic              in_accept;
    logic              slot_free;
    logic              sweep_end;
    logic [QLEN_W-1:0] qlen_eff;
    logic [7:0]        pos_used;
    logic [7:0]        end_dist;
    logic [CNT_W+8:0]  cnt_ext;
    logic [CNT_W+8:0]  best_ext;
    logic              ans_found;

    nedm_bcast_t       bcast;
    logic [IDX_W-1:0]  wr_idx;
    nedm_wave_t        chain [0:QUERY_MAX];
    logic [QUERY_MAX-1:0] chain_valid;

    // ---------------- cell chain ----------------

    assign chain[0].valid = launch_valid_reg;
    assign chain[0].diag  = launch_diag_reg;
    assign chain[0].left  = launch_left_reg;

    genvar gi;
    generate
        for (gi = 0; gi < QUERY_MAX; gi++)
        begin : g_cell
            nedm_cell
            #(
                .QUERY_MAX  (QUERY_MAX),
                .CELL_INDEX (gi)
            )
            u_cell
            (
                .clk          (clk),
                .rst_n        (rst_n),
                .bcast        (bcast),
                .wr_idx       (wr_idx),
                .query_length (qlen_reg),
                .wave_in      (chain[gi]),
                .wave_out     (chain[gi+1])
            );
            assign chain_valid[gi] = chain[gi+1].valid;
        end
    endgenerate

    // ---------------- control ----------------

    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign sweep_end = (state_reg == ST_SWEEP) && chain[QUERY_MAX].valid;
    assign end_dist  = chain[QUERY_MAX].left;
    assign cnt_ext   = {9'd0, cnt_reg};
    assign best_ext  = {9'd0, best_idx_reg};
    assign qlen_eff  = qdone_reg ? '0 : qlen_reg;
    assign pos_used  = open_reg ? pos_reg : 8'd0;
    assign ans_found = have_best_reg && (qlen_reg != '0);
    assign sym_reg_valid_unused = 1'b0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_FINISH)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (operation == OP_CANDIDATE && cnt_reg < CNT_MAX)
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (chain[QUERY_MAX].valid)
                begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        cfg_ready = 1'b1;

        qlen_next      = qlen_reg;
        qdone_next     = qdone_reg;
        pos_next       = pos_reg;
        open_next      = open_reg;
        cnt_next       = cnt_reg;
        best_idx_next  = best_idx_reg;
        best_cost_next = best_cost_reg;
        have_best_next = have_best_reg;
        thr_next       = cfg_valid ? cfg_data : thr_reg;

        sym_next          = sym_reg;
        init_next         = init_reg;
        last_next         = last_reg;
        launch_valid_next = 1'b0;
        launch_diag_next  = launch_diag_reg;
        launch_left_next  = launch_left_reg;

        pend_kind_next   = pend_kind_reg;
        pend_idx_next    = pend_idx_reg;
        pend_dist_next   = pend_dist_reg;
        pend_within_next = pend_within_reg;
        pend_found_next  = pend_found_reg;

        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_idx_next    = out_idx_reg;
        out_dist_next   = out_dist_reg;
        out_within_next = out_within_reg;
        out_found_next  = out_found_reg;

        bcast.init    = init_reg;
        bcast.symbol  = sym_reg;
        bcast.wr_en   = 1'b0;
        bcast.wr_byte = symbol;
        wr_idx        = qlen_eff[IDX_W-1:0];

        if (in_accept)
        begin
            unique case (operation)
                OP_QUERY:
                begin
                    if (qdone_reg)
                    begin
                        // new query: drop the search and any open candidate
                        qdone_next     = 1'b0;
                        pos_next       = 8'd0;
                        open_next      = 1'b0;
                        cnt_next       = '0;
                        best_idx_next  = '0;
                        best_cost_next = DIST_SAT;
                        have_best_next = 1'b0;
                    end
                    qlen_next = qlen_eff;
                    if (qlen_eff < QLEN_MAX)
                    begin
                        bcast.wr_en = 1'b1;
                        qlen_next   = qlen_eff + QLEN_W'(1);
                    end
                    if (last)
                    begin
                        qdone_next = 1'b1;
                    end
                end
                OP_CANDIDATE:
                begin
                    qdone_next = 1'b1;
                    if (cnt_reg < CNT_MAX)
                    begin
                        sym_next          = symbol;
                        init_next         = !open_reg;
                        last_next         = last;
                        open_next         = 1'b1;
                        launch_valid_next = 1'b1;
                        launch_diag_next  = pos_used;
                        launch_left_next  = sat_inc(pos_used);
                        pos_next          = sat_inc(pos_used);
                    end
                end
                OP_FINISH:
                begin
                    pend_kind_next   = KIND_ANSWER;
                    pend_idx_next    = best_ext[8:0];
                    pend_dist_next   = best_cost_reg;
                    pend_found_next  = ans_found;
                    pend_within_next = ans_found && (best_cost_reg <= thr_reg);
                    pos_next         = 8'd0;
                    open_next        = 1'b0;
                    cnt_next         = '0;
                    best_idx_next    = '0;
                    best_cost_next   = DIST_SAT;
                    have_best_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        if (sweep_end && last_reg)
        begin
            // candidate done; with an empty query, end_dist is the candidate length
            if (!have_best_reg || end_dist < best_cost_reg)
            begin
                best_cost_next = end_dist;
                best_idx_next  = cnt_reg;
                have_best_next = 1'b1;
            end
            pend_kind_next   = KIND_DISTANCE;
            pend_idx_next    = cnt_ext[8:0];
            pend_dist_next   = end_dist;
            pend_within_next = 1'b0;
            pend_found_next  = 1'b0;
            cnt_next         = cnt_reg + CNT_W'(1);
            open_next        = 1'b0;
            pos_next         = 8'd0;
        end

        if (state_reg == ST_EMIT && slot_free)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = pend_kind_reg;
            out_idx_next    = pend_idx_reg;
            out_dist_next   = pend_dist_reg;
            out_within_next = pend_within_reg;
            out_found_next  = pend_found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            qlen_reg         <= '0;
            qdone_reg        <= 1'b0;
            pos_reg          <= 8'd0;
            open_reg         <= 1'b0;
            cnt_reg          <= '0;
            best_idx_reg     <= '0;
            best_cost_reg    <= DIST_SAT;
            have_best_reg    <= 1'b0;
            thr_reg          <= THRESHOLD_RESET;
            launch_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            qlen_reg         <= qlen_next;
            qdone_reg        <= qdone_next;
            pos_reg          <= pos_next;
            open_reg         <= open_next;
            cnt_reg          <= cnt_next;
            best_idx_reg     <= best_idx_next;
            best_cost_reg    <= best_cost_next;
            have_best_reg    <= have_best_next;
            thr_reg          <= thr_next;
            launch_valid_reg <= launch_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg         <= sym_next;
        init_reg        <= init_next;
        last_reg        <= last_next;
        launch_diag_reg <= launch_diag_next;
        launch_left_reg <= launch_left_next;
        pend_kind_reg   <= pend_kind_next;
        pend_idx_reg    <= pend_idx_next;
        pend_dist_reg   <= pend_dist_next;
        pend_within_reg <= pend_within_next;
        pend_found_reg  <= pend_found_next;
        out_kind_reg    <= out_kind_next;
        out_idx_reg     <= out_idx_next;
        out_dist_reg    <= out_dist_next;
        out_within_reg  <= out_within_next;
        out_found_reg   <= out_found_next;
    end

    assign out_valid        = out_valid_reg || sym_reg_valid_unused;
    assign kind             = out_kind_reg;
    assign candidate_index  = out_idx_reg;
    assign distance         = out_dist_reg;
    assign within_threshold = out_within_reg;
    assign found            = out_found_reg;

`ifndef ASSERT_OFF
    a_single_wave: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({launch_valid_reg, chain_valid}))
        else $error("more than one wavefront in the cell chain");

    a_end_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        chain[QUERY_MAX].valid |-> state_reg == ST_SWEEP)
        else $error("wavefront left the chain outside a sweep");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && slot_free) |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("pending result not moved to the output register");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("candidate count beyond its limit");

    a_no_best_sat: assert property (@(posedge clk) disable iff (!rst_n)
        !have_best_reg |-> best_cost_reg == DIST_SAT)
        else $error("best distance set without a best candidate");
`endif

endmodule

[hdl/nedm_cell.sv]
// one query position of the edit-distance chain
// holds one query byte and one dp row entry, passes the wavefront on
// depends on nedm_pkg
module nedm_cell
#(
    parameter int QUERY_MAX  = nedm_pkg::QUERY_MAX_DEF,
    parameter int CELL_INDEX = 0
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  nedm_pkg::nedm_bcast_t              bcast,
    input  logic [$clog2(QUERY_MAX)-1:0]       wr_idx,
    input  logic [$clog2(QUERY_MAX+1)-1:0]     query_length,
    input  nedm_pkg::nedm_wave_t               wave_in,
    output nedm_pkg::nedm_wave_t               wave_out
);
    import nedm_pkg::*;

    localparam int IDX_W  = $clog2(QUERY_MAX);
    localparam int QLEN_W = $clog2(QUERY_MAX+1);
    localparam logic [IDX_W-1:0]  CELL_IDX = IDX_W'(CELL_INDEX);
    localparam logic [QLEN_W-1:0] CELL_POS = QLEN_W'(CELL_INDEX);
    localparam logic [7:0] INIT_VAL = (CELL_INDEX + 1 > 255) ? 8'd255 : 8'(CELL_INDEX + 1);

    logic [7:0] qbyte_reg;
    logic [7:0] qbyte_next;
    logic [7:0] row_reg;
    logic [7:0] row_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] diag_reg;
    logic [7:0] diag_next;
    logic [7:0] left_reg;
    logic [7:0] left_next;

    logic       active;
    logic [7:0] up;
    logic [8:0] sub_sum;
    logic [7:0] sub_val;
    logic [7:0] up_val;
    logic [7:0] left_val;
    logic [7:0] min_a;
    logic [7:0] v;

    always_comb
    begin
        active  = wave_in.valid && (CELL_POS < query_length);
        up      = bcast.init ? INIT_VAL : row_reg;
        sub_sum = {1'b0, wave_in.diag} + {8'd0, (qbyte_reg != bcast.symbol)};
        sub_val = sub_sum[8] ? DIST_SAT : sub_sum[7:0];
        up_val  = sat_inc(up);
        left_val = sat_inc(wave_in.left);
        min_a   = (up_val < sub_val) ? up_val : sub_val;
        v       = (left_val < min_a) ? left_val : min_a;

        qbyte_next = (bcast.wr_en && wr_idx == CELL_IDX) ? bcast.wr_byte : qbyte_reg;
        row_next   = active ? v : row_reg;
        valid_next = wave_in.valid;
        // positions past the query end pass the wavefront through untouched
        diag_next  = active ? up : wave_in.diag;
        left_next  = active ? v : wave_in.left;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qbyte_reg <= qbyte_next;
        row_reg   <= row_next;
        diag_reg  <= diag_next;
        left_reg  <= left_next;
    end

    assign wave_out.valid = valid_reg;
    assign wave_out.diag  = diag_reg;
    assign wave_out.left  = left_reg;

endmodule
